@@ src/assert_macros.svh @@
// Assertion macros used by the indexed list sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ILMF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ilmf: property violated");
// Check that a condition never holds on a rising clock edge outside reset.
`define ILMF_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ilmf: forbidden condition seen");
`else
`define ILMF_ASSERT(lbl, clk, rst, prop)
`define ILMF_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ src/ilmf_pkg.sv @@
// Types, command and status codes shared by the indexed list modules.
`default_nettype none
package ilmf_pkg;
   localparam int unsigned CMD_W     = 4;
   localparam int unsigned IDX_W     = 7;
   localparam int unsigned CNT_W     = 31;
   localparam int unsigned HDL_W     = 32;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned ST_W      = 3;
   localparam int unsigned OIDX_W    = 6;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd100;

   localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_READ      = 4'd3;
   localparam logic [CMD_W-1:0] CMD_SET_COUNT = 4'd4;
   localparam logic [CMD_W-1:0] CMD_SET_TEXT  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_MAX       = 4'd6;
   localparam logic [CMD_W-1:0] CMD_FILTER    = 4'd7;
   localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd8;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_NEG     = 3'd1;
   localparam logic [ST_W-1:0] ST_LONG    = 3'd2;
   localparam logic [ST_W-1:0] ST_BAD_IDX = 3'd3;
   localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;
   localparam logic [ST_W-1:0] ST_FULL    = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [IDX_W-1:0]        index;
      logic signed [CNT_W:0]   count_value;
      logic [HDL_W-1:0]        text_handle;
      logic [LEN_W-1:0]        text_length;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [OIDX_W-1:0] entry_index;
      logic [CNT_W-1:0]  entry_count_value;
      logic [HDL_W-1:0]  entry_text_handle;
      logic [IDX_W-1:0]  table_size;
      logic              match_valid;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic             we_count;
      logic             we_handle;
      logic [CNT_W-1:0] count;
      logic [HDL_W-1:0] handle;
   } mem_wr_type;
endpackage
`default_nettype wire

@@ src/indexed_list_with_max_and_filter.sv @@
// Top level of the indexed list: text length register, sequencer and entry memory.
// An item that is rejected or touches no entry passes from the idle state through
// the reply state into the result register; an item that walks entries first reads
// them through the registered read port, one read per cycle while no filter match
// is held back (insert, remove, max and filter walk the table; an append reads none);
// a stalled result channel holds the reply, and a new item is taken only when idle.
// Reset: entry count cleared, text length limit set to 100, memory left unwritten.
`default_nettype none
module indexed_list_with_max_and_filter
   import ilmf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_item,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [LEN_W-1:0] csr_data
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [LEN_W-1:0] max_len_ff, max_len_in;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [CNT_W-1:0] rd_count;
   logic [HDL_W-1:0] rd_handle;
   logic [AW-1:0]    wr_addr;
   mem_wr_type       wr;

   // text length limit register, always ready
   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   ilmf_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .max_len   (max_len_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_count  (rd_count),
      .rd_handle (rd_handle),
      .wr_addr   (wr_addr),
      .wr        (wr)
   );

   ilmf_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_count  (rd_count),
      .rd_handle (rd_handle),
      .wr_addr   (wr_addr),
      .wr        (wr)
   );
endmodule
`default_nettype wire

@@ src/ilmf_store.sv @@
// Entry memory: counts and handles, one write port and one registered read port.
`default_nettype none
module ilmf_store
   import ilmf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   parameter int unsigned AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [CNT_W-1:0] rd_count,
   output logic      [HDL_W-1:0] rd_handle,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire mem_wr_type       wr
);
   logic [CNT_W-1:0] count_mem  [DEPTH];
   logic [HDL_W-1:0] handle_mem [DEPTH];
   logic [CNT_W-1:0] rd_count_ff;
   logic [HDL_W-1:0] rd_handle_ff;

   // write the selected fields of one entry
   always_ff @(posedge clock) begin
      if (wr.we_count) begin
         count_mem[wr_addr] <= wr.count;
      end
      if (wr.we_handle) begin
         handle_mem[wr_addr] <= wr.handle;
      end
   end

   // read one entry, hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_count_ff  <= count_mem[rd_addr];
         rd_handle_ff <= handle_mem[rd_addr];
      end
   end

   assign rd_count  = rd_count_ff;
   assign rd_handle = rd_handle_ff;
endmodule
`default_nettype wire

@@ src/ilmf_ctrl.sv @@
// Command sequencer: decode, walk the entry memory, build and hold result items.
`default_nettype none
`include "assert_macros.svh"
module ilmf_ctrl
   import ilmf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   parameter int unsigned AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [LEN_W-1:0] max_len,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_item,
   output logic                  rd_en,
   output logic      [AW-1:0]    rd_addr,
   input  wire logic [CNT_W-1:0] rd_count,
   input  wire logic [HDL_W-1:0] rd_handle,
   output logic      [AW-1:0]    wr_addr,
   output mem_wr_type            wr
);
   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_WALK  = 3'b010,
      S_REPLY = 3'b100
   } state_type;

   localparam logic [IDX_W-1:0] DEPTH_N = IDX_W'(DEPTH);

   state_type        state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] val_ff, val_in;
   logic [HDL_W-1:0] hdl_ff, hdl_in;
   logic [IDX_W-1:0] held_ff, held_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic             dv_ff, dv_in;
   logic [AW-1:0]    raddr_ff, raddr_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             acc;
   logic             neg;
   logic             too_long;
   logic [ST_W-1:0]  acc_status;
   logic             acc_walk;
   logic             acc_ins;
   logic [IDX_W-1:0] acc_idx;
   logic [IDX_W-1:0] acc_ptr;
   logic [IDX_W-1:0] acc_rem;
   logic [IDX_W-1:0] acc_held;
   logic             walking;
   logic             down;
   logic             is_ins;
   logic             is_match;
   logic             need_push;
   logic             out_free;
   logic             consume;
   logic             issue;
   logic             capture;
   logic             shift_we;
   logic             walk_done;
   logic             out_push;
   rsp_type          cap;

   assign req_ready = (state_ff == S_IDLE);
   assign acc       = req_valid && req_ready;
   assign neg       = req_item.count_value[CNT_W];
   assign too_long  = req_item.text_length > max_len;

   // check the command against the table and plan its walk
   always_comb begin
      acc_status = ST_OK;
      acc_walk   = 1'b0;
      acc_ins    = 1'b0;
      acc_idx    = req_item.index;
      acc_ptr    = '0;
      acc_rem    = '0;
      acc_held   = held_ff;
      case (req_item.command)
         CMD_APPEND, CMD_INSERT: begin
            if ((req_item.command == CMD_INSERT) && (req_item.index > held_ff)) begin
               acc_status = ST_BAD_IDX;
            end else if (neg) begin
               acc_status = ST_NEG;
            end else if (too_long) begin
               acc_status = ST_LONG;
            end else if (held_ff >= DEPTH_N) begin
               acc_status = ST_FULL;
            end else begin
               acc_walk = 1'b1;
               acc_ins  = 1'b1;
               if (req_item.command == CMD_APPEND) begin
                  acc_idx = held_ff;
               end
               acc_rem  = held_ff - acc_idx;
               acc_ptr  = held_ff - 7'd1;
               acc_held = held_ff + 7'd1;
            end
         end
         CMD_REMOVE: begin
            if (held_ff == '0) begin
               acc_status = ST_EMPTY;
            end else if (req_item.index >= held_ff) begin
               acc_status = ST_BAD_IDX;
            end else begin
               acc_walk = 1'b1;
               acc_ptr  = req_item.index;
               acc_rem  = held_ff - req_item.index;
               acc_held = held_ff - 7'd1;
            end
         end
         CMD_READ: begin
            if (req_item.index >= held_ff) begin
               acc_status = ST_BAD_IDX;
            end else begin
               acc_walk = 1'b1;
               acc_ptr  = req_item.index;
               acc_rem  = 7'd1;
            end
         end
         CMD_SET_COUNT: begin
            if (req_item.index >= held_ff) begin
               acc_status = ST_BAD_IDX;
            end else if (neg) begin
               acc_status = ST_NEG;
            end else begin
               acc_walk = 1'b1;
               acc_ptr  = req_item.index;
               acc_rem  = 7'd1;
            end
         end
         CMD_SET_TEXT: begin
            if (req_item.index >= held_ff) begin
               acc_status = ST_BAD_IDX;
            end else if (too_long) begin
               acc_status = ST_LONG;
            end else begin
               acc_walk = 1'b1;
               acc_ptr  = req_item.index;
               acc_rem  = 7'd1;
            end
         end
         CMD_MAX: begin
            if (held_ff == '0) begin
               acc_status = ST_EMPTY;
            end else begin
               acc_walk = 1'b1;
               acc_rem  = held_ff;
            end
         end
         CMD_FILTER: begin
            if (neg) begin
               acc_status = ST_NEG;
            end else begin
               acc_walk = 1'b1;
               acc_rem  = held_ff;
            end
         end
         default: begin
            acc_status = ST_OK;
         end
      endcase
   end

   // walk control: one read a cycle, stall while a filter match cannot leave
   assign walking   = (state_ff == S_WALK);
   assign is_ins    = (cmd_ff == CMD_APPEND) || (cmd_ff == CMD_INSERT);
   assign down      = is_ins;
   assign is_match  = rd_count > val_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign need_push = dv_ff && (cmd_ff == CMD_FILTER) && is_match && res_ff.match_valid;
   assign consume   = dv_ff && !(need_push && !out_free);
   assign issue     = walking && (rem_ff != '0) && !(dv_ff && !consume);
   assign walk_done = walking && (rem_ff == '0) && !dv_ff;
   assign shift_we  = consume && (is_ins ||
                      ((cmd_ff == CMD_REMOVE) && (raddr_ff != idx_ff[AW-1:0])));

   assign rd_en   = issue;
   assign rd_addr = ptr_ff[AW-1:0];

   // decide whether the arriving entry becomes the reported one
   always_comb begin
      capture = 1'b0;
      case (cmd_ff)
         CMD_READ, CMD_SET_COUNT, CMD_SET_TEXT: begin
            capture = consume;
         end
         CMD_REMOVE: begin
            capture = consume && (raddr_ff == idx_ff[AW-1:0]);
         end
         CMD_MAX: begin
            capture = consume && ((raddr_ff == '0) ||
                                  (rd_count > res_ff.entry_count_value));
         end
         CMD_FILTER: begin
            capture = consume && is_match;
         end
         default: begin
            capture = 1'b0;
         end
      endcase
   end

   // merge read data with the fields this command replaces
   always_comb begin
      cap                   = '0;
      cap.status            = ST_OK;
      cap.entry_index       = OIDX_W'(raddr_ff);
      cap.entry_count_value = (cmd_ff == CMD_SET_COUNT) ? val_ff : rd_count;
      cap.entry_text_handle = (cmd_ff == CMD_SET_TEXT) ? hdl_ff : rd_handle;
      cap.match_valid       = cmd_ff inside {CMD_READ, CMD_MAX, CMD_FILTER};
   end

   // memory writes: shift during the walk, the new fields once it ends
   always_comb begin
      wr      = '0;
      wr_addr = idx_ff[AW-1:0];
      if (shift_we) begin
         wr_addr      = down ? (raddr_ff + AW'(1)) : (raddr_ff - AW'(1));
         wr.we_count  = 1'b1;
         wr.we_handle = 1'b1;
         wr.count     = rd_count;
         wr.handle    = rd_handle;
      end else if (walk_done) begin
         wr.we_count  = is_ins || (cmd_ff == CMD_SET_COUNT);
         wr.we_handle = is_ins || (cmd_ff == CMD_SET_TEXT);
         wr.count     = val_ff;
         wr.handle    = hdl_ff;
      end
   end

   // next state of the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               state_in = acc_walk ? S_WALK : S_REPLY;
            end
         end
         S_WALK: begin
            if (walk_done) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // latch the command, advance the walk, hold the reported entry
   always_comb begin
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      hdl_in   = hdl_ff;
      held_in  = held_ff;
      ptr_in   = ptr_ff;
      rem_in   = rem_ff;
      raddr_in = raddr_ff;
      res_in   = res_ff;
      dv_in    = issue ? 1'b1 : (consume ? 1'b0 : dv_ff);
      if (acc) begin
         cmd_in  = req_item.command;
         idx_in  = acc_idx;
         val_in  = req_item.count_value[CNT_W-1:0];
         hdl_in  = req_item.text_handle;
         held_in = acc_held;
         ptr_in  = acc_ptr;
         rem_in  = acc_rem;
         res_in  = '0;
         res_in.status = acc_status;
         if (acc_ins) begin
            res_in.entry_index       = OIDX_W'(acc_idx);
            res_in.entry_count_value = req_item.count_value[CNT_W-1:0];
            res_in.entry_text_handle = req_item.text_handle;
         end
      end
      if (issue) begin
         ptr_in   = down ? (ptr_ff - 7'd1) : (ptr_ff + 7'd1);
         rem_in   = rem_ff - 7'd1;
         raddr_in = ptr_ff[AW-1:0];
      end
      if (capture) begin
         res_in = cap;
      end
   end

   // output register: a filter match mid-walk or the closing item
   assign out_push = (need_push && consume) || ((state_ff == S_REPLY) && out_free);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (out_push) begin
         rsp_in            = res_ff;
         rsp_in.table_size = held_ff;
         rsp_in.last       = (state_ff == S_REPLY);
         rsp_valid_in      = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         dv_ff        <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         dv_ff        <= dv_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      hdl_ff   <= hdl_in;
      ptr_ff   <= ptr_in;
      raddr_ff <= raddr_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   `ILMF_NEVER(a_held_bound, clock, reset, held_ff > DEPTH_N)
   `ILMF_ASSERT(a_held_stable, clock, reset, (state_ff != S_IDLE) |=> (held_ff == $past(held_ff)))
   `ILMF_NEVER(a_push_blocked, clock, reset, out_push && rsp_valid_ff && !rsp_ready)
   `ILMF_NEVER(a_read_outside_walk, clock, reset, dv_ff && (state_ff != S_WALK))
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the indexed list: directed edge cases, a full table and paced random traffic.
module testbench;
   import ilmf_pkg::*;

   localparam int unsigned     TABLE_DEPTH  = DEPTH_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_CODE_TOP = 4'hF;
   localparam int              DRAIN_CAP    = 200000;
   localparam int              SHOWN_ERRORS = 10;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_item = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_item;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_data = '0;

   // Shadow of the table contents and the text length register
   logic [CNT_W-1:0] row_count [TABLE_DEPTH];
   logic [HDL_W-1:0] row_handle [TABLE_DEPTH];
   logic [IDX_W-1:0] rows_held = '0;
   logic [LEN_W-1:0] len_limit = MAX_LEN_RESET;
   bit               growing = 1'b1;

   rsp_type awaited_results[$];
   int      failures = 0;
   int      commands_sent = 0;
   int      results_seen = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   indexed_list_with_max_and_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Queue one expected result item
   task automatic push_result(input logic [ST_W-1:0] st, input logic [OIDX_W-1:0] pos,
                              input logic [CNT_W-1:0] cnt, input logic [HDL_W-1:0] hdl,
                              input logic mv, input logic fin);
      rsp_type r;
      r.status            = st;
      r.entry_index       = pos;
      r.entry_count_value = cnt;
      r.entry_text_handle = hdl;
      r.table_size        = rows_held;
      r.match_valid       = mv;
      r.last              = fin;
      awaited_results.push_back(r);
   endtask

   task automatic push_error(input logic [ST_W-1:0] st);
      push_result(st, '0, '0, '0, 1'b0, 1'b1);
   endtask

   task automatic push_entry(input logic [IDX_W-1:0] pos, input logic mv);
      push_result(ST_OK, pos[OIDX_W-1:0], row_count[pos], row_handle[pos], mv, 1'b1);
   endtask

   // Apply one command to the shadow table and queue the result items it produces
   task automatic predict_list_response(input req_type c);
      logic [IDX_W-1:0] pos;
      logic [CNT_W-1:0] thr;
      logic [CNT_W-1:0] old_cnt;
      logic [HDL_W-1:0] old_hdl;
      logic             neg;
      logic             too_long;
      int               best;
      int               hits;
      pos      = c.index;
      neg      = c.count_value[CNT_W];
      thr      = c.count_value[CNT_W-1:0];
      too_long = c.text_length > len_limit;
      case (c.command)
         CMD_APPEND, CMD_INSERT: begin
            if (c.command == CMD_INSERT && pos > rows_held) push_error(ST_BAD_IDX);
            else if (neg) push_error(ST_NEG);
            else if (too_long) push_error(ST_LONG);
            else if (rows_held >= TABLE_DEPTH) push_error(ST_FULL);
            else begin
               if (c.command == CMD_APPEND) pos = rows_held;
               for (int i = rows_held; i > pos; i--) begin
                  row_count[i]  = row_count[i-1];
                  row_handle[i] = row_handle[i-1];
               end
               row_count[pos]  = thr;
               row_handle[pos] = c.text_handle;
               rows_held++;
               push_entry(pos, 1'b0);
            end
         end
         CMD_REMOVE: begin
            if (rows_held == 0) push_error(ST_EMPTY);
            else if (pos >= rows_held) push_error(ST_BAD_IDX);
            else begin
               old_cnt = row_count[pos];
               old_hdl = row_handle[pos];
               for (int i = pos; i + 1 < rows_held; i++) begin
                  row_count[i]  = row_count[i+1];
                  row_handle[i] = row_handle[i+1];
               end
               rows_held--;
               push_result(ST_OK, pos[OIDX_W-1:0], old_cnt, old_hdl, 1'b0, 1'b1);
            end
         end
         CMD_READ: begin
            if (pos >= rows_held) push_error(ST_BAD_IDX);
            else push_entry(pos, 1'b1);
         end
         CMD_SET_COUNT: begin
            if (pos >= rows_held) push_error(ST_BAD_IDX);
            else if (neg) push_error(ST_NEG);
            else begin
               row_count[pos] = thr;
               push_entry(pos, 1'b0);
            end
         end
         CMD_SET_TEXT: begin
            if (pos >= rows_held) push_error(ST_BAD_IDX);
            else if (too_long) push_error(ST_LONG);
            else begin
               row_handle[pos] = c.text_handle;
               push_entry(pos, 1'b0);
            end
         end
         CMD_MAX: begin
            if (rows_held == 0) push_error(ST_EMPTY);
            else begin
               best = 0;
               for (int i = 1; i < rows_held; i++)
                  if (row_count[i] > row_count[best]) best = i;
               push_entry(IDX_W'(best), 1'b1);
            end
         end
         CMD_FILTER: begin
            if (neg) push_error(ST_NEG);
            else begin
               hits = 0;
               for (int i = 0; i < rows_held; i++) begin
                  if (row_count[i] > thr) begin
                     push_result(ST_OK, OIDX_W'(i), row_count[i], row_handle[i], 1'b1, 1'b0);
                     hits++;
                  end
               end
               // Mark the final match, or report an empty scan
               if (hits == 0) push_result(ST_OK, '0, '0, '0, 1'b0, 1'b1);
               else awaited_results[awaited_results.size()-1].last = 1'b1;
            end
         end
         default: begin
            push_result(ST_OK, '0, '0, '0, 1'b0, 1'b1);
         end
      endcase
   endtask

   task automatic note_failure(input string what);
      failures++;
      if (failures <= SHOWN_ERRORS) $display("%0t: %s", $time, what);
   endtask

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      note_failure($sformatf("%s mismatch, expected %0h, got %0h", field, want, got));
   endtask

   // Compare one accepted result item with the oldest expectation
   task automatic compare_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (awaited_results.size() == 0) begin
         note_failure("result item arrived with none expected");
      end else begin
         want = awaited_results.pop_front();
         if (got.status !== want.status)
            report_field("status", 64'(want.status), 64'(got.status));
         if (got.entry_index !== want.entry_index)
            report_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
         if (got.entry_count_value !== want.entry_count_value)
            report_field("entry_count_value", 64'(want.entry_count_value),
                         64'(got.entry_count_value));
         if (got.entry_text_handle !== want.entry_text_handle)
            report_field("entry_text_handle", 64'(want.entry_text_handle),
                         64'(got.entry_text_handle));
         if (got.table_size !== want.table_size)
            report_field("table_size", 64'(want.table_size), 64'(got.table_size));
         if (got.match_valid !== want.match_valid)
            report_field("match_valid", 64'(want.match_valid), 64'(got.match_valid));
         if (got.last !== want.last)
            report_field("last", 64'(want.last), 64'(got.last));
      end
   endtask

   // Stall the result channel at random and check every accepted item
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) compare_result(rsp_item);
   end

   // Send one item, with random idle cycles ahead of it, and predict its results
   task automatic send_command(input req_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= c;
      do @(posedge clock); while (!req_ready);
      commands_sent++;
      predict_list_response(c);
   endtask

   // Drop valid and hold until every expected item has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_text_limit(input logic [LEN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      len_limit = value;
   endtask

   function automatic req_type make_req(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] pos,
                                        input logic signed [CNT_W:0] cnt,
                                        input logic [HDL_W-1:0] hdl,
                                        input logic [LEN_W-1:0] len);
      req_type c;
      c.command     = op;
      c.index       = pos;
      c.count_value = cnt;
      c.text_handle = hdl;
      c.text_length = len;
      return c;
   endfunction

   // Counts lean on a small range so that ties for the maximum are common
   function automatic logic signed [CNT_W:0] random_count();
      case ($urandom_range(15))
         0:             return {1'b1, 31'($urandom)};
         1:             return 32'h7FFF_FFFF;
         2, 3, 4, 5, 6: return 32'($urandom_range(0, 20));
         default:       return {1'b0, 31'($urandom)};
      endcase
   endfunction

   // Build one random command, biased to fill or drain the table
   task automatic send_random_command();
      req_type c;
      int      pick;
      if (rows_held >= TABLE_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      if (rows_held == 0) growing = 1'b1;
      pick = $urandom_range(99);
      if (growing) begin
         if (pick < 35)      c.command = CMD_APPEND;
         else if (pick < 62) c.command = CMD_INSERT;
         else if (pick < 67) c.command = CMD_REMOVE;
         else if (pick < 75) c.command = CMD_READ;
         else if (pick < 81) c.command = CMD_SET_COUNT;
         else if (pick < 87) c.command = CMD_SET_TEXT;
         else if (pick < 92) c.command = CMD_MAX;
         else if (pick < 97) c.command = CMD_FILTER;
         else                c.command = 4'($urandom_range(CMD_COUNT, CMD_CODE_TOP));
      end else begin
         if (pick < 8)       c.command = CMD_APPEND;
         else if (pick < 16) c.command = CMD_INSERT;
         else if (pick < 58) c.command = CMD_REMOVE;
         else if (pick < 66) c.command = CMD_READ;
         else if (pick < 73) c.command = CMD_SET_COUNT;
         else if (pick < 80) c.command = CMD_SET_TEXT;
         else if (pick < 87) c.command = CMD_MAX;
         else if (pick < 96) c.command = CMD_FILTER;
         else                c.command = 4'($urandom_range(CMD_COUNT, CMD_CODE_TOP));
      end
      // Mostly valid positions, with the boundary and wild values mixed in
      case ($urandom_range(19))
         0:       c.index = 7'($urandom_range(0, 127));
         1:       c.index = rows_held;
         default: c.index = (rows_held == 0) ? '0 : 7'($urandom_range(0, rows_held - 1));
      endcase
      if (c.command == CMD_FILTER) begin
         case ($urandom_range(9))
            0:       c.count_value = {1'b1, 31'($urandom)};
            1:       c.count_value = '0;
            2:       c.count_value = 32'h7FFF_FFFF;
            3, 4:    c.count_value = random_count();
            default: c.count_value = (rows_held == 0) ? '0 :
                        {1'b0, row_count[$urandom_range(0, rows_held - 1)]};
         endcase
      end else begin
         c.count_value = random_count();
      end
      c.text_handle = $urandom;
      case ($urandom_range(9))
         0:       c.text_length = 16'($urandom);
         1:       c.text_length = len_limit;
         2:       c.text_length = (len_limit == 16'hFFFF) ? len_limit : len_limit + 16'd1;
         default: c.text_length = 16'($urandom_range(0, len_limit));
      endcase
      send_command(c);
   endtask

   // Most commands against an empty table, unknown codes included
   task automatic test_empty_table();
      send_command(make_req(CMD_MAX, 0, 0, 0, 0));
      send_command(make_req(CMD_REMOVE, 0, 0, 0, 0));
      send_command(make_req(CMD_READ, 0, 0, 0, 0));
      send_command(make_req(CMD_FILTER, 0, 0, 0, 0));
      send_command(make_req(CMD_COUNT, 0, 0, 0, 0));
      send_command(make_req(CMD_CODE_TOP, 7'h7F, -1, 32'hFFFF_FFFF, 16'hFFFF));
      send_command(make_req(CMD_SET_COUNT, 0, 5, 0, 0));
      send_command(make_req(CMD_INSERT, 1, 5, 0, 0));
   endtask

   // Field extremes, check precedence, ties for the maximum and the filter
   task automatic test_entry_edits();
      send_command(make_req(CMD_APPEND, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd100));
      send_command(make_req(CMD_APPEND, 0, -1, 1, 10));
      send_command(make_req(CMD_APPEND, 0, 3, 2, 16'd101));
      send_command(make_req(CMD_INSERT, 5, 3, 3, 10));
      send_command(make_req(CMD_INSERT, 7'h7F, -32'sd2147483648, 4, 16'hFFFF));
      send_command(make_req(CMD_INSERT, 0, 0, 0, 0));
      send_command(make_req(CMD_INSERT, 2, 7, 32'h1234_5678, 50));
      send_command(make_req(CMD_READ, 1, 0, 0, 0));
      send_command(make_req(CMD_SET_COUNT, 0, 32'h7FFF_FFFF, 0, 0));
      send_command(make_req(CMD_MAX, 0, 0, 0, 0));
      send_command(make_req(CMD_SET_COUNT, 3, -1, 0, 0));
      send_command(make_req(CMD_SET_COUNT, 1, -5, 0, 0));
      send_command(make_req(CMD_SET_TEXT, 1, 0, 32'hDEAD_BEEF, 16'd101));
      send_command(make_req(CMD_SET_TEXT, 2, 0, 32'hA5A5_5A5A, 16'd100));
      send_command(make_req(CMD_FILTER, 0, -7, 0, 0));
      send_command(make_req(CMD_FILTER, 0, 6, 0, 0));
      send_command(make_req(CMD_REMOVE, 3, 0, 0, 0));
      send_command(make_req(CMD_REMOVE, 0, 0, 0, 0));
      send_command(make_req(CMD_READ, 63, 0, 0, 0));
   endtask

   // Fill the table, then probe the full case and a scan of every entry
   task automatic test_full_table();
      while (rows_held < TABLE_DEPTH)
         send_command(make_req(CMD_APPEND, 7'($urandom), {1'b0, 31'($urandom)}, $urandom,
                               16'($urandom_range(0, len_limit))));
      send_command(make_req(CMD_APPEND, 0, 1, 1, 1));
      send_command(make_req(CMD_INSERT, IDX_W'(TABLE_DEPTH), 1, 1, 1));
      send_command(make_req(CMD_INSERT, IDX_W'(TABLE_DEPTH + 1), 1, 1, 1));
      send_command(make_req(CMD_READ, IDX_W'(TABLE_DEPTH - 1), 0, 0, 0));
      send_command(make_req(CMD_FILTER, 0, 0, 0, 0));
      send_command(make_req(CMD_MAX, 0, 0, 0, 0));
      growing = 1'b0;
   endtask

   // One pacing phase of random traffic under a fresh text length limit
   task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct,
                                      input logic [LEN_W-1:0] limit);
      wait_for_results();
      write_text_limit(limit);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (items) send_random_command();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_entry_edits();
      test_full_table();
      test_random_traffic(44, 0, 0, 16'hFFFF);
      test_random_traffic(44, 52, 0, 16'h0000);
      test_random_traffic(44, 0, 52, 16'($urandom));
      test_random_traffic(44, 19, 19, MAX_LEN_RESET);
      // Let the last results drain, then allow for a final table walk
      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_CAP && awaited_results.size() != 0; n++) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (awaited_results.size() != 0)
         note_failure($sformatf("%0d expected result items never arrived",
                                awaited_results.size()));
      $display("Sent %0d commands and checked %0d result items, including a full table,",
               commands_sent, results_seen);
      $display("under four pacing phases and text length limits of 0, 100 and 65535.");
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
